>>> hw/rtl/nnrot_pkg.sv
// Shared constants, types and fixed-point helpers of the nearest-neighbour rotator.
package nnrot_pkg;

  // Pixel store geometry.
  localparam int unsigned MaxWidth  = 64;
  localparam int unsigned MaxHeight = 64;
  localparam int unsigned Depth     = MaxWidth * MaxHeight;
  localparam int unsigned AddrW     = $clog2(Depth);

  // Datapath widths.
  localparam int unsigned DimW   = 11;  // effective source dimension, up to 64
  localparam int unsigned CoordW = 12;  // signed box coordinates and offsets
  localparam int unsigned ProdW  = 28;  // signed coordinate times Q2.14 product
  localparam int unsigned FracW  = 14;  // fraction bits of the angle registers

  localparam logic signed [31:0] TruncBias = 32'((1 << FracW) - 1);

  // Configuration port.
  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 24;

  localparam logic [CfgIdxW-1:0] RegCos    = 3'd0;
  localparam logic [CfgIdxW-1:0] RegSin    = 3'd1;
  localparam logic [CfgIdxW-1:0] RegWidth  = 3'd2;
  localparam logic [CfgIdxW-1:0] RegHeight = 3'd3;
  localparam logic [CfgIdxW-1:0] RegBg     = 3'd4;

  // Item function codes.
  localparam logic FuncWrite = 1'b0;
  localparam logic FuncRead  = 1'b1;

  // Configuration as seen by the datapath units.
  typedef struct packed {
    logic signed [15:0] cos_angle;
    logic signed [15:0] sin_angle;
    logic [DimW-1:0]    eff_w;
    logic [DimW-1:0]    eff_h;
  } cfg_t;

  // Rotated bounding box.
  typedef struct packed {
    logic signed [CoordW-1:0] off_x;
    logic signed [CoordW-1:0] off_y;
    logic [7:0]               width;
    logic [7:0]               height;
  } box_t;

  // Inverse mapping result.
  typedef struct packed {
    logic             hit;
    logic [AddrW-1:0] addr;
  } map_t;

  // Divide by 2^14 with truncation toward zero.
  function automatic logic signed [31:0] trunc_q14(input logic signed [31:0] x);
    logic signed [31:0] bias;
    bias = x[31] ? TruncBias : 32'sd0;
    return (x + bias) >>> FracW;
  endfunction

  // Clamp a dimension register to the store limit.
  function automatic logic [DimW-1:0] eff_dim(input logic [6:0] r, input int unsigned lim);
    logic [DimW-1:0] v;
    v = {4'b0, r};
    return (v > DimW'(lim)) ? DimW'(lim) : v;
  endfunction

endpackage

>>> hw/rtl/nnrot_store.sv
// Source pixel store: one write port and one registered read port.
module nnrot_store (
  input  logic                       clk_i,
  input  logic                       we_i,
  input  logic [nnrot_pkg::AddrW-1:0] waddr_i,
  input  logic [31:0]                wdata_i,
  input  logic                       re_i,
  input  logic [nnrot_pkg::AddrW-1:0] raddr_i,
  output logic [31:0]                rdata_o
);

  logic [31:0] mem_q [nnrot_pkg::Depth];
  logic [31:0] rdata_q;

  // Write port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port.
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> hw/rtl/nnrot_box.sv
// Bounding box unit: rotates the source corners forward after every configuration change.
module nnrot_box (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   start_i,
  input  nnrot_pkg::cfg_t        cfg_i,
  output logic                   busy_o,
  output nnrot_pkg::box_t        box_o
);

  localparam int unsigned PW = nnrot_pkg::ProdW;
  localparam int unsigned CW = nnrot_pkg::CoordW;

  logic [2:0] stg_q, stg_d;

  logic signed [11:0] w_s, h_s;
  logic signed [PW-1:0] pwc_q, phs_q, pws_q, phc_q;
  logic signed [PW-1:0] pwc_d, phs_d, pws_d, phc_d;
  logic signed [CW-1:0] cx1_q, cy1_q, cx2_q, cy2_q, cx3_q, cy3_q;
  logic signed [CW-1:0] cx1_d, cy1_d, cx2_d, cy2_d, cx3_d, cy3_d;
  logic signed [CW-1:0] minx, maxx, miny, maxy, dx, dy;
  nnrot_pkg::box_t box_q, box_d;

  // Stage sequence: products, corners, extents.
  assign stg_d  = {stg_q[1:0], start_i};
  assign busy_o = |stg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stg_q <= 3'b001;
    end else begin
      stg_q <= stg_d;
    end
  end

  // Dimension times sine and cosine.
  always_comb begin
    w_s   = $signed({1'b0, cfg_i.eff_w});
    h_s   = $signed({1'b0, cfg_i.eff_h});
    pwc_d = PW'(w_s) * PW'(cfg_i.cos_angle);
    phs_d = PW'(h_s) * PW'(cfg_i.sin_angle);
    pws_d = PW'(w_s) * PW'(cfg_i.sin_angle);
    phc_d = PW'(h_s) * PW'(cfg_i.cos_angle);
  end

  always_ff @(posedge clk_i) begin
    pwc_q <= pwc_d;
    phs_q <= phs_d;
    pws_q <= pws_d;
    phc_q <= phc_d;
  end

  // Rotated corners, truncated toward zero.
  always_comb begin
    cx1_d = CW'(nnrot_pkg::trunc_q14(32'(pwc_q)));
    cy1_d = CW'(nnrot_pkg::trunc_q14(32'(pws_q)));
    cx2_d = CW'(nnrot_pkg::trunc_q14(32'sd0 - 32'(phs_q)));
    cy2_d = CW'(nnrot_pkg::trunc_q14(32'(phc_q)));
    cx3_d = CW'(nnrot_pkg::trunc_q14(32'(pwc_q) - 32'(phs_q)));
    cy3_d = CW'(nnrot_pkg::trunc_q14(32'(pws_q) + 32'(phc_q)));
  end

  always_ff @(posedge clk_i) begin
    cx1_q <= cx1_d;
    cy1_q <= cy1_d;
    cx2_q <= cx2_d;
    cy2_q <= cy2_d;
    cx3_q <= cx3_d;
    cy3_q <= cy3_d;
  end

  // Extents over the four corners; the origin corner keeps the minimum at or below zero.
  always_comb begin
    minx = '0;
    maxx = '0;
    miny = '0;
    maxy = '0;
    if (cx1_q < minx) minx = cx1_q;
    if (cx2_q < minx) minx = cx2_q;
    if (cx3_q < minx) minx = cx3_q;
    if (cx1_q > maxx) maxx = cx1_q;
    if (cx2_q > maxx) maxx = cx2_q;
    if (cx3_q > maxx) maxx = cx3_q;
    if (cy1_q < miny) miny = cy1_q;
    if (cy2_q < miny) miny = cy2_q;
    if (cy3_q < miny) miny = cy3_q;
    if (cy1_q > maxy) maxy = cy1_q;
    if (cy2_q > maxy) maxy = cy2_q;
    if (cy3_q > maxy) maxy = cy3_q;
    dx = maxx - minx;
    dy = maxy - miny;
    box_d.off_x  = minx;
    box_d.off_y  = miny;
    box_d.width  = (dx > CW'(255)) ? 8'hFF : dx[7:0];
    box_d.height = (dy > CW'(255)) ? 8'hFF : dy[7:0];
  end

  always_ff @(posedge clk_i) begin
    if (stg_q[2]) begin
      box_q <= box_d;
    end
  end

  assign box_o = box_q;

endmodule

>>> hw/rtl/nnrot_map.sv
// Inverse mapping: output position back into the source image and store address.
module nnrot_map (
  input  logic            clk_i,
  input  logic            load_i,
  input  logic [6:0]      column_i,
  input  logic [6:0]      line_i,
  input  nnrot_pkg::cfg_t cfg_i,
  input  nnrot_pkg::box_t box_i,
  output nnrot_pkg::map_t map_o
);

  localparam int unsigned PW = nnrot_pkg::ProdW;
  localparam int unsigned CW = nnrot_pkg::CoordW;

  logic [6:0] col_q, row_q;
  logic signed [CW-1:0] i_s, j_s;
  logic signed [PW-1:0] ic_q, js_q, jc_q, is_q;
  logic inbox_q;
  logic signed [31:0] nx, ny, w_s, h_s;
  logic [31:0] lin;

  // Item position, held for the whole item.
  always_ff @(posedge clk_i) begin
    if (load_i) begin
      col_q <= column_i;
      row_q <= line_i;
    end
  end

  // Shift by the box offset and multiply by sine and cosine.
  assign i_s = box_i.off_x + $signed({5'b0, col_q});
  assign j_s = box_i.off_y + $signed({5'b0, row_q});

  always_ff @(posedge clk_i) begin
    ic_q    <= PW'(i_s) * PW'(cfg_i.cos_angle);
    js_q    <= PW'(j_s) * PW'(cfg_i.sin_angle);
    jc_q    <= PW'(j_s) * PW'(cfg_i.cos_angle);
    is_q    <= PW'(i_s) * PW'(cfg_i.sin_angle);
    inbox_q <= ({1'b0, col_q} < box_i.width) && ({1'b0, row_q} < box_i.height);
  end

  // Source point, bounds check and store address.
  always_comb begin
    nx  = nnrot_pkg::trunc_q14(32'(ic_q) + 32'(js_q));
    ny  = nnrot_pkg::trunc_q14(32'(jc_q) - 32'(is_q));
    w_s = $signed(32'(cfg_i.eff_w));
    h_s = $signed(32'(cfg_i.eff_h));
    lin = $unsigned(ny) * 32'(nnrot_pkg::MaxWidth) + $unsigned(nx);
    map_o.hit  = inbox_q && (nx >= 32'sd0) && (nx < w_s) && (ny >= 32'sd0) && (ny < h_s);
    map_o.addr = lin[nnrot_pkg::AddrW-1:0];
  end

endmodule

>>> hw/rtl/nearest_neighbour_image_rotator.sv
// Top level of the nearest-neighbour image rotator: registers, sequencing and result stage.
//
//   channel   signals                                        direction
//   item      start_i, busy_o, func_i, column_i, line_i,     in
//             pixel_in_i
//   result    done_o, pixel_out_o, hit_o, out_width_o,       out
//             out_height_o
//   config    cfg_we_i, cfg_idx_i, cfg_wdata_i               in
//
// An item passes through the position registers, the products, the address and store read
// and the result register. The single store read port and the one item in flight set the
// pace; a new item can be taken in the cycle its predecessor's result is shown.
// After reset and every configuration write the box unit computes products, corners
// and extents with busy_o high. No clearing pass: the store is undefined until written.
// The result beat is shown for one cycle on done_o; there is no stall.
module nearest_neighbour_image_rotator (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            start_i,
  output logic                            busy_o,
  input  logic                            func_i,
  input  logic [6:0]                      column_i,
  input  logic [6:0]                      line_i,
  input  logic [31:0]                     pixel_in_i,
  output logic                            done_o,
  output logic [31:0]                     pixel_out_o,
  output logic                            hit_o,
  output logic [7:0]                      out_width_o,
  output logic [7:0]                      out_height_o,
  input  logic                            cfg_we_i,
  input  logic [nnrot_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  logic [nnrot_pkg::CfgDataW-1:0]  cfg_wdata_i
);

  logic signed [15:0] cos_q, sin_q;
  logic [6:0]  width_q, height_q;
  logic [23:0] bg_q;
  nnrot_pkg::cfg_t cfg;
  nnrot_pkg::box_t box;
  nnrot_pkg::map_t map;
  logic box_busy;

  logic accept;
  logic [2:0] stg_q;
  logic done_q;
  logic [2:0] func_q;
  logic hit_q;
  logic [31:0] rdata;
  logic [31:0] swap_bg;
  logic [31:0] pixel_d, pixel_q;
  logic hit_d, hit_out_q;
  logic [7:0] width_out_q, height_out_q;
  logic wr_en;
  logic [31:0] wr_lin;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cos_q    <= 16'sh4000;
      sin_q    <= 16'sh0000;
      width_q  <= 7'd64;
      height_q <= 7'd64;
      bg_q     <= 24'h000000;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        nnrot_pkg::RegCos:    cos_q    <= cfg_wdata_i[15:0];
        nnrot_pkg::RegSin:    sin_q    <= cfg_wdata_i[15:0];
        nnrot_pkg::RegWidth:  width_q  <= cfg_wdata_i[6:0];
        nnrot_pkg::RegHeight: height_q <= cfg_wdata_i[6:0];
        nnrot_pkg::RegBg:     bg_q     <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  always_comb begin
    cfg.cos_angle = cos_q;
    cfg.sin_angle = sin_q;
    cfg.eff_w     = nnrot_pkg::eff_dim(width_q, nnrot_pkg::MaxWidth);
    cfg.eff_h     = nnrot_pkg::eff_dim(height_q, nnrot_pkg::MaxHeight);
  end

  // Bounding box, recomputed after every configuration write.
  nnrot_box u_box (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cfg_we_i),
    .cfg_i   (cfg),
    .busy_o  (box_busy),
    .box_o   (box)
  );

  // Handshake and item sequencing; one item in flight, so reads never overlap writes.
  assign busy_o = (|stg_q) || box_busy || cfg_we_i;
  assign accept = start_i && !busy_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stg_q  <= '0;
      done_q <= 1'b0;
    end else begin
      stg_q  <= {stg_q[1:0], accept};
      done_q <= stg_q[2];
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      func_q[0] <= func_i;
    end
    func_q[2:1] <= func_q[1:0];
  end

  // Source pixel writes go straight into the store on the accepting edge.
  assign wr_lin = 32'(line_i) * 32'(nnrot_pkg::MaxWidth) + 32'(column_i);
  assign wr_en  = accept && (func_i == nnrot_pkg::FuncWrite) &&
                  (32'(column_i) < 32'(nnrot_pkg::MaxWidth)) &&
                  (32'(line_i) < 32'(nnrot_pkg::MaxHeight));

  nnrot_map u_map (
    .clk_i    (clk_i),
    .load_i   (accept),
    .column_i (column_i),
    .line_i   (line_i),
    .cfg_i    (cfg),
    .box_i    (box),
    .map_o    (map)
  );

  nnrot_store u_store (
    .clk_i   (clk_i),
    .we_i    (wr_en),
    .waddr_i (wr_lin[nnrot_pkg::AddrW-1:0]),
    .wdata_i (pixel_in_i),
    .re_i    (stg_q[1]),
    .raddr_i (map.addr),
    .rdata_o (rdata)
  );

  // Hit flag lines up with the store read data.
  assign hit_d = map.hit && (func_q[1] == nnrot_pkg::FuncRead);

  always_ff @(posedge clk_i) begin
    hit_q <= hit_d;
  end

  // Result stage: stored pixel, swapped background or zero for a write.
  assign swap_bg = {8'h00, bg_q[7:0], bg_q[15:8], bg_q[23:16]};

  always_comb begin
    if (func_q[2] == nnrot_pkg::FuncRead) begin
      pixel_d = hit_q ? rdata : swap_bg;
    end else begin
      pixel_d = '0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (stg_q[2]) begin
      pixel_q      <= pixel_d;
      hit_out_q    <= hit_q;
      width_out_q  <= box.width;
      height_out_q <= box.height;
    end
  end

  assign done_o       = done_q;
  assign pixel_out_o  = pixel_q;
  assign hit_o        = hit_out_q;
  assign out_width_o  = width_out_q;
  assign out_height_o = height_out_q;

endmodule

>>> hw/rtl/nnrot_checker.sv
// Port-level checks of the rotator, bound to the top level.
module nnrot_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        start_i,
  input logic        busy_o,
  input logic        func_i,
  input logic        done_o,
  input logic [31:0] pixel_out_o,
  input logic        hit_o,
  input logic [7:0]  out_width_o,
  input logic [7:0]  out_height_o
);

  // Every accepted item returns its result beat on done_o.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o) |-> ##4 done_o)
    else $error("accepted item did not produce a result beat");

  // Result beats are never back to back, since one item is in flight at a time.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !done_o)
    else $error("result beat repeated");

  // A write item returns zero pixel and no hit.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && ($past(func_i, 4) == nnrot_pkg::FuncWrite)) |-> (pixel_out_o == 32'd0 && !hit_o))
    else $error("write result carries pixel data");

  // A hit implies a non-empty rotated box.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && hit_o) |-> (out_width_o != 8'd0 && out_height_o != 8'd0))
    else $error("hit reported for an empty box");

endmodule

bind nearest_neighbour_image_rotator nnrot_checker u_nnrot_checker (.*);

>>> tb/tb.sv
// Testbench of the nearest-neighbour image rotator: directed and random pixel traffic.
`timescale 1ns / 100ps

module tb;

  // One result beat as the block reports it.
  typedef struct packed {
    logic [31:0] pixel;
    logic        hit;
    logic [7:0]  width;
    logic [7:0]  height;
  } rot_result_t;

  // Rotated bounding box: offsets of its top-left corner and its saturated size.
  typedef struct {
    longint off_x;
    longint off_y;
    longint nw;
    longint nh;
  } rot_box_t;

  logic                           clk_i;
  logic                           rst_ni;
  logic                           start_i;
  logic                           busy_o;
  logic                           func_i;
  logic [6:0]                     column_i;
  logic [6:0]                     line_i;
  logic [31:0]                    pixel_in_i;
  logic                           done_o;
  logic [31:0]                    pixel_out_o;
  logic                           hit_o;
  logic [7:0]                     out_width_o;
  logic [7:0]                     out_height_o;
  logic                           cfg_we_i;
  logic [nnrot_pkg::CfgIdxW-1:0]  cfg_idx_i;
  logic [nnrot_pkg::CfgDataW-1:0] cfg_wdata_i;

  // Shadow copy of the configuration registers.
  logic signed [15:0] cos_q;
  logic signed [15:0] sin_q;
  logic [6:0]         src_w;
  logic [6:0]         src_h;
  logic [23:0]        bg_color;

  // Shadow copy of the pixel store, with a mark for every entry written so far.
  logic [31:0] source_mem [nnrot_pkg::Depth];
  bit          source_written [nnrot_pkg::Depth];

  rot_result_t rotated_results_q[$];
  int unsigned mismatch_count;
  int unsigned burst_left;
  int unsigned random_items;

  nearest_neighbour_image_rotator uut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start_i      (start_i),
    .busy_o       (busy_o),
    .func_i       (func_i),
    .column_i     (column_i),
    .line_i       (line_i),
    .pixel_in_i   (pixel_in_i),
    .done_o       (done_o),
    .pixel_out_o  (pixel_out_o),
    .hit_o        (hit_o),
    .out_width_o  (out_width_o),
    .out_height_o (out_height_o),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_wdata_i  (cfg_wdata_i)
  );

  // 10 ns clock.
  always begin
    clk_i = 1'b1;
    #5;
    clk_i = 1'b0;
    #5;
  end

  // Dimension register clamped to the store limit.
  function automatic longint clamp_dim(input logic [6:0] r, input int unsigned lim);
    return (r > lim) ? longint'(lim) : longint'(r);
  endfunction

  // Forward-rotate the four source corners and take their extent.
  function automatic rot_box_t rotated_box();
    rot_box_t b;
    longint   c, s, w, h;
    longint   cx [4];
    longint   cy [4];
    longint   mnx, mxx, mny, mxy;
    c = cos_q;
    s = sin_q;
    w = clamp_dim(src_w, nnrot_pkg::MaxWidth);
    h = clamp_dim(src_h, nnrot_pkg::MaxHeight);
    cx[0] = 0;
    cy[0] = 0;
    cx[1] = (w * c) / 16384;
    cy[1] = (w * s) / 16384;
    cx[2] = (-h * s) / 16384;
    cy[2] = (h * c) / 16384;
    cx[3] = (w * c - h * s) / 16384;
    cy[3] = (w * s + h * c) / 16384;
    mnx = 0;
    mxx = 0;
    mny = 0;
    mxy = 0;
    for (int k = 1; k < 4; k++) begin
      if (cx[k] < mnx) mnx = cx[k];
      if (cx[k] > mxx) mxx = cx[k];
      if (cy[k] < mny) mny = cy[k];
      if (cy[k] > mxy) mxy = cy[k];
    end
    b.off_x = (mnx < 0) ? mnx : 0;
    b.off_y = (mny < 0) ? mny : 0;
    b.nw    = (mxx - mnx > 255) ? 255 : mxx - mnx;
    b.nh    = (mxy - mny > 255) ? 255 : mxy - mny;
    return b;
  endfunction

  // Inverse-map an output position; returns 1 and the store address on a hit.
  function automatic bit source_lookup(input logic [6:0] col, input logic [6:0] row,
                                       output int unsigned addr);
    rot_box_t b;
    longint   c, s, w, h, i, j, nx, ny;
    b    = rotated_box();
    c    = cos_q;
    s    = sin_q;
    w    = clamp_dim(src_w, nnrot_pkg::MaxWidth);
    h    = clamp_dim(src_h, nnrot_pkg::MaxHeight);
    addr = 0;
    if (longint'(col) < b.nw && longint'(row) < b.nh) begin
      i  = b.off_x + longint'(col);
      j  = b.off_y + longint'(row);
      nx = (i * c + j * s) / 16384;
      ny = (j * c - i * s) / 16384;
      if (nx >= 0 && nx < w && ny >= 0 && ny < h) begin
        addr = int'(ny) * nnrot_pkg::MaxWidth + int'(nx);
        return 1'b1;
      end
    end
    return 1'b0;
  endfunction

  // Expected result of one accepted item; a write also updates the shadow store.
  function automatic rot_result_t rotate_predict(input logic f, input logic [6:0] col,
                                                 input logic [6:0] row,
                                                 input logic [31:0] pix);
    rot_result_t r;
    rot_box_t    b;
    int unsigned addr;
    b        = rotated_box();
    r.width  = b.nw[7:0];
    r.height = b.nh[7:0];
    r.pixel  = '0;
    r.hit    = 1'b0;
    if (f == nnrot_pkg::FuncWrite) begin
      if (col < nnrot_pkg::MaxWidth && row < nnrot_pkg::MaxHeight) begin
        addr                 = row * nnrot_pkg::MaxWidth + col;
        source_mem[addr]     = pix;
        source_written[addr] = 1'b1;
      end
    end else begin
      r.pixel = {8'h00, bg_color[7:0], bg_color[15:8], bg_color[23:16]};
      r.hit   = source_lookup(col, row, addr);
      if (r.hit) r.pixel = source_mem[addr];
    end
    return r;
  endfunction

  // Drive one item and hold it until the block takes it.
  task automatic send_item(input logic f, input logic [6:0] col, input logic [6:0] row,
                           input logic [31:0] pix);
    @(negedge clk_i);
    start_i    = 1'b1;
    func_i     = f;
    column_i   = col;
    line_i     = row;
    pixel_in_i = pix;
    do @(posedge clk_i); while (busy_o !== 1'b0);
    rotated_results_q.push_back(rotate_predict(f, col, row, pix));
  endtask

  // A read that would land on an unwritten entry gets that entry written first.
  task automatic issue_read(input logic [6:0] col, input logic [6:0] row);
    int unsigned addr;
    if (source_lookup(col, row, addr) && !source_written[addr])
      send_item(nnrot_pkg::FuncWrite, 7'(addr % nnrot_pkg::MaxWidth),
                7'(addr / nnrot_pkg::MaxWidth), $urandom);
    send_item(nnrot_pkg::FuncRead, col, row, $urandom);
  endtask

  // Sender works in bursts with random gaps between them.
  task automatic pace_sender();
    int unsigned gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? $urandom_range(8, 20) : $urandom_range(1, 5);
      repeat (gap) begin
        @(negedge clk_i);
        start_i = 1'b0;
      end
      burst_left = $urandom_range(1, 30);
    end else begin
      burst_left--;
    end
  endtask

  task automatic wait_idle();
    do @(posedge clk_i); while (busy_o !== 1'b0);
  endtask

  // Write one configuration register and mirror it.
  task automatic write_reg(input logic [nnrot_pkg::CfgIdxW-1:0] idx,
                           input logic [nnrot_pkg::CfgDataW-1:0] value);
    wait_idle();
    @(negedge clk_i);
    cfg_we_i    = 1'b1;
    cfg_idx_i   = idx;
    cfg_wdata_i = value;
    @(posedge clk_i);
    case (idx)
      nnrot_pkg::RegCos:    cos_q    = value[15:0];
      nnrot_pkg::RegSin:    sin_q    = value[15:0];
      nnrot_pkg::RegWidth:  src_w    = value[6:0];
      nnrot_pkg::RegHeight: src_h    = value[6:0];
      nnrot_pkg::RegBg:     bg_color = value[23:0];
      default: ;
    endcase
    @(negedge clk_i);
    cfg_we_i = 1'b0;
  endtask

  // Let every pending result drain, then let the block settle.
  task automatic drain_results();
    @(negedge clk_i);
    start_i = 1'b0;
    while (rotated_results_q.size() != 0) @(posedge clk_i);
    repeat (6) @(posedge clk_i);
  endtask

  // Reprogram all registers; unused upper data bits carry random junk.
  task automatic apply_setting(input logic [15:0] c, input logic [15:0] s,
                               input logic [6:0] w, input logic [6:0] h,
                               input logic [23:0] bg);
    drain_results();
    write_reg(nnrot_pkg::RegCos, {8'($urandom), c});
    write_reg(nnrot_pkg::RegSin, {8'($urandom), s});
    write_reg(nnrot_pkg::RegWidth, {17'($urandom), w});
    write_reg(nnrot_pkg::RegHeight, {17'($urandom), h});
    write_reg(nnrot_pkg::RegBg, bg);
  endtask

  // One random item: mostly writes inside the source and reads inside the box.
  task automatic random_item();
    rot_box_t    b;
    longint      w, h;
    logic [6:0]  col, row;
    b = rotated_box();
    w = clamp_dim(src_w, nnrot_pkg::MaxWidth);
    h = clamp_dim(src_h, nnrot_pkg::MaxHeight);
    pace_sender();
    if ($urandom_range(0, 99) < 30) begin
      if (w > 0 && h > 0 && $urandom_range(0, 9) != 0) begin
        col = 7'($urandom_range(0, int'(w) - 1));
        row = 7'($urandom_range(0, int'(h) - 1));
      end else begin
        col = 7'($urandom);
        row = 7'($urandom);
      end
      send_item(nnrot_pkg::FuncWrite, col, row, $urandom);
    end else begin
      if (b.nw > 0 && b.nh > 0 && $urandom_range(0, 7) != 0) begin
        col = 7'($urandom_range(0, (b.nw > 128) ? 127 : int'(b.nw) - 1));
        row = 7'($urandom_range(0, (b.nh > 128) ? 127 : int'(b.nh) - 1));
      end else begin
        col = 7'($urandom);
        row = 7'($urandom);
      end
      issue_read(col, row);
    end
  endtask

  // Identity rotation after reset: store corners, ignored writes, reads off the box.
  task automatic test_reset_state();
    send_item(nnrot_pkg::FuncWrite, 7'd0, 7'd0, 32'hFFFF_FFFF);
    send_item(nnrot_pkg::FuncWrite, 7'd63, 7'd63, 32'h0000_0000);
    send_item(nnrot_pkg::FuncWrite, 7'd63, 7'd0, 32'hA5A5_A5A5);
    send_item(nnrot_pkg::FuncWrite, 7'd0, 7'd63, 32'h5A5A_5A5A);
    send_item(nnrot_pkg::FuncWrite, 7'd64, 7'd5, 32'h1234_5678);
    send_item(nnrot_pkg::FuncWrite, 7'd5, 7'd64, 32'h8765_4321);
    send_item(nnrot_pkg::FuncWrite, 7'd127, 7'd127, 32'hDEAD_BEEF);
    issue_read(7'd0, 7'd0);
    issue_read(7'd63, 7'd63);
    issue_read(7'd63, 7'd0);
    issue_read(7'd0, 7'd63);
    issue_read(7'd31, 7'd32);
    issue_read(7'd64, 7'd0);
    issue_read(7'd0, 7'd64);
    issue_read(7'd127, 7'd127);
  endtask

  // Quarter turns, diagonal, saturated box, empty and clamped sources.
  task automatic test_extreme_settings();
    logic [15:0] c_tab  [10] = '{16'sd0, -16'sd16384, 16'sd0, 16'sd11585, -16'sd32768,
                                 16'sd32767, 16'sd16384, 16'sd16384, -16'sd16384,
                                 16'sd16384};
    logic [15:0] s_tab  [10] = '{16'sd16384, 16'sd0, -16'sd16384, 16'sd11585, -16'sd32768,
                                 16'sd32767, 16'sd0, 16'sd0, 16'sd16384, 16'sd0};
    logic [6:0]  w_tab  [10] = '{7'd64, 7'd64, 7'd37, 7'd16, 7'd64, 7'd127, 7'd0, 7'd1,
                                 7'd3, 7'd64};
    logic [6:0]  h_tab  [10] = '{7'd64, 7'd64, 7'd5, 7'd9, 7'd64, 7'd127, 7'd0, 7'd1,
                                 7'd70, 7'd1};
    logic [23:0] bg_tab [10] = '{24'hFFFFFF, 24'h123456, 24'hFF00FF, 24'h00FF00, 24'hABCDEF,
                                 24'h000000, 24'hFFFFFF, 24'h0F0F0F, 24'hF0F0F0, 24'h800001};
    for (int k = 0; k < 10; k++) begin
      apply_setting(c_tab[k], s_tab[k], w_tab[k], h_tab[k], bg_tab[k]);
      issue_read(7'd0, 7'd0);
      issue_read(7'd127, 7'd127);
      repeat (30) random_item();
    end
  endtask

  // Random settings, mostly true rotations of small images.
  task automatic test_random_settings();
    real         theta;
    logic [15:0] c, s;
    logic [6:0]  w, h;
    int unsigned pick, phase_items;
    while (random_items < 850) begin
      pick = $urandom_range(0, 99);
      if (pick < 60) begin
        theta = $urandom_range(0, 359) * 3.14159265358979 / 180.0;
        c     = 16'($rtoi($cos(theta) * 16384.0));
        s     = 16'($rtoi($sin(theta) * 16384.0));
      end else if (pick < 85) begin
        c = 16'($urandom_range(0, 32768) - 16384);
        s = 16'($urandom_range(0, 32768) - 16384);
      end else begin
        c = 16'($urandom);
        s = 16'($urandom);
      end
      pick = $urandom_range(0, 9);
      if (pick < 7) begin
        w = 7'($urandom_range(1, 16));
        h = 7'($urandom_range(1, 16));
      end else if (pick < 9) begin
        w = 7'($urandom_range(17, 64));
        h = 7'($urandom_range(1, 64));
      end else begin
        w = 7'($urandom);
        h = 7'($urandom);
      end
      apply_setting(c, s, w, h, 24'($urandom));
      phase_items = $urandom_range(60, 120);
      repeat (phase_items) random_item();
      random_items += phase_items;
    end
  endtask

  // Compare every result beat with the oldest expectation.
  always @(posedge clk_i) begin : check_result
    rot_result_t got, want;
    if (rst_ni === 1'b1 && done_o === 1'b1) begin
      got = {pixel_out_o, hit_o, out_width_o, out_height_o};
      if (rotated_results_q.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10)
          $display("unexpected result beat: pixel %h hit %b width %0d height %0d",
                   got.pixel, got.hit, got.width, got.height);
      end else begin
        want = rotated_results_q.pop_front();
        if (got !== want) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("mismatch: expected pixel %h hit %b width %0d height %0d, %s",
                     want.pixel, want.hit, want.width, want.height,
                     $sformatf("got pixel %h hit %b width %0d height %0d",
                               got.pixel, got.hit, got.width, got.height));
        end
      end
    end
  end

  // Hard stop if the block hangs.
  initial begin
    #5_000_000;
    $display("tb: failure");
    $finish;
  end

  initial begin
    rst_ni         = 1'b0;
    start_i        = 1'b0;
    func_i         = nnrot_pkg::FuncWrite;
    column_i       = '0;
    line_i         = '0;
    pixel_in_i     = '0;
    cfg_we_i       = 1'b0;
    cfg_idx_i      = nnrot_pkg::RegCos;
    cfg_wdata_i    = '0;
    cos_q          = 16'sd16384;
    sin_q          = 16'sd0;
    src_w          = 7'd64;
    src_h          = 7'd64;
    bg_color       = '0;
    mismatch_count = 0;
    burst_left     = 0;
    random_items   = 0;
    for (int k = 0; k < nnrot_pkg::Depth; k++) source_written[k] = 1'b0;
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    test_reset_state();
    test_extreme_settings();
    test_random_settings();

    drain_results();
    repeat (4) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
